[src/assert_macros.svh]
// assertion macros used by the checker file bffa_checker.sv
// clocked on clk, most of them disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AST_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define AST_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

// next-cycle implication, active through reset
`define AST_NXT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[src/bffa_pkg.sv]
// shared types, codes and helpers of the bitmap allocator
// no dependencies
`timescale 1ns / 1ps

package bffa_pkg;

  localparam int CFG_LEN_W  = 10;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int INDEX_W    = 12;
  localparam int VALUE_W    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
  localparam logic MAP_NODE  = 1'b0;
  localparam logic MAP_BLOCK = 1'b1;

  localparam logic [7:0] FULL_BYTE = 8'hff;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_LOOK,
    ST_FINISH
  } bffa_state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic step;
    logic commit;
    logic fail;
    logic emit;
  } bffa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic start_ok;
    logic is_free;
    logic byte_full;
    logic more;
    logic rsp_open;
  } bffa_status_t;

  function automatic logic [2:0] first_zero(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (!b[i]) pos = 3'(i);
    end
    return pos;
  endfunction

endpackage

[src/bffa_ram.sv]
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

[src/bffa_ctrl.sv]
// sequencer of the bitmap allocator: clear pass, byte scan, result hand-off
// depends on bffa_pkg
`timescale 1ns / 1ps

module bffa_ctrl import bffa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  bffa_status_t status,
  output bffa_cmd_t    cmd
);

  bffa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (!status.start_ok) begin
          cmd.fail   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (status.is_free || !status.byte_full) begin
          cmd.commit = 1'b1;
          state_next = ST_FINISH;
        end else if (status.more) begin
          cmd.step   = 1'b1;
          state_next = ST_START;
        end else begin
          cmd.fail   = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.rsp_open) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

[src/bffa_dp.sv]
// datapath of the bitmap allocator: config, both maps, scan address, result words
// depends on bffa_pkg and bffa_ram
`timescale 1ns / 1ps

module bffa_dp import bffa_pkg::*; #(
  parameter int MAP_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  action,
  input  logic                  which_map,
  input  logic [INDEX_W-1:0]    free_index,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  success,
  output logic [VALUE_W-1:0]    result_value,
  input  bffa_cmd_t             cmd,
  output bffa_status_t          status
);

  localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int LEN_W  = $clog2(MAP_BYTES + 1);

  logic [CFG_LEN_W-1:0]  node_len;
  logic [CFG_LEN_W-1:0]  block_len;
  logic [CFG_DATA_W-1:0] data_start;

  logic                  item_free;
  logic                  item_blk;
  logic [INDEX_W-4:0]    item_fbyte;
  logic [2:0]            item_bit;
  logic [ADDR_W-1:0]     cur_addr;
  logic                  pend_ok;
  logic [VALUE_W-1:0]    pend_val;

  logic [CFG_LEN_W-1:0]  len_sel;
  logic [LEN_W-1:0]      eff_len;
  logic [7:0]            node_rd, blk_rd, rd, mod_byte, wdata;
  logic [2:0]            low_bit;
  logic                  node_we, blk_we;
  logic [31:0]           fbyte_wide;
  logic [VALUE_W-1:0]    bit_idx, alloc_val;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_len   <= CFG_LEN_W'(512);
      block_len  <= CFG_LEN_W'(512);
      data_start <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_LEN:   node_len   <= cfg_data[CFG_LEN_W-1:0];
        CFG_BLOCK_LEN:  block_len  <= cfg_data[CFG_LEN_W-1:0];
        CFG_DATA_START: data_start <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective length, saturated to the map size
  assign len_sel = item_blk ? block_len : node_len;
  assign eff_len = (32'(len_sel) > 32'(MAP_BYTES)) ? LEN_W'(MAP_BYTES) : LEN_W'(len_sel);

  assign fbyte_wide = 32'(free_index[INDEX_W-1:3]);

  // item registers and scan address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_free  <= (action == ACT_FREE);
      item_blk   <= (which_map == MAP_BLOCK);
      item_fbyte <= free_index[INDEX_W-1:3];
      item_bit   <= free_index[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_addr <= '0;
    end else if (cmd.load) begin
      cur_addr <= (action == ACT_FREE) ? fbyte_wide[ADDR_W-1:0] : '0;
    end else if (cmd.clr_step || cmd.step) begin
      cur_addr <= cur_addr + ADDR_W'(1);
    end
  end

  // maps
  assign rd        = item_blk ? blk_rd : node_rd;
  assign low_bit   = first_zero(rd);
  assign mod_byte  = item_free ? (rd & ~(8'd1 << item_bit)) : (rd | (8'd1 << low_bit));
  assign wdata     = cmd.clr_step ? 8'd0 : mod_byte;
  assign node_we   = cmd.clr_step || (cmd.commit && !item_blk);
  assign blk_we    = cmd.clr_step || (cmd.commit && item_blk);

  bffa_ram #(.WIDTH(8), .DEPTH(MAP_BYTES), .AW(ADDR_W)) u_node_map (
    .clk   (clk),
    .we    (node_we),
    .addr  (cur_addr),
    .wdata (wdata),
    .rdata (node_rd)
  );

  bffa_ram #(.WIDTH(8), .DEPTH(MAP_BYTES), .AW(ADDR_W)) u_block_map (
    .clk   (clk),
    .we    (blk_we),
    .addr  (cur_addr),
    .wdata (wdata),
    .rdata (blk_rd)
  );

  assign bit_idx   = VALUE_W'({cur_addr, low_bit});
  assign alloc_val = item_blk ? bit_idx + data_start : bit_idx;

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pend_ok  <= 1'b1;
      pend_val <= item_free ? '0 : alloc_val;
    end else if (cmd.fail) begin
      pend_ok  <= 1'b0;
      pend_val <= '0;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      success      <= pend_ok;
      result_value <= pend_val;
    end
  end

  assign status.clr_last  = (cur_addr == ADDR_W'(MAP_BYTES - 1));
  assign status.start_ok  = item_free ? (32'(item_fbyte) < 32'(eff_len)) : (eff_len != '0);
  assign status.is_free   = item_free;
  assign status.byte_full = (rd == FULL_BYTE);
  assign status.more      = (32'(cur_addr) + 32'd1 < 32'(eff_len));
  assign status.rsp_open  = !rsp_valid || !rsp_stall;

endmodule

[src/bitmap_first_free_allocator.sv]
// top level of the bitmap first-free allocator
// depends on bffa_pkg, bffa_ctrl, bffa_dp
//
// request channel (req_valid / req_stall) carries one word: action, which_map,
// free_index. response channel (rsp_valid / rsp_stall) returns one word per
// request: success and result_value. config is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is idle,
// the block itself has no check for this. one request is worked at a time:
// START checks the length and sends a failure straight to FINISH; LOOK checks
// the registered ram read of the byte at the map address, commits a free or a
// zero bit, goes back to START for the next byte or fails at the length's end.
// FINISH loads the response register, and the block then takes the next request.
// after rst the block runs a clear pass over all MAP_BYTES bytes of both maps,
// holding req_stall high; config writes are taken during it.
// the response sits in an output register: while rsp_stall is high it holds,
// and the block still accepts the next request, then waits with the new
// result until the register is free.
`timescale 1ns / 1ps

module bitmap_first_free_allocator import bffa_pkg::*; #(
  parameter int MAP_BYTES = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic                  action,
  input  logic                  which_map,
  input  logic [INDEX_W-1:0]    free_index,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  success,
  output logic [VALUE_W-1:0]    result_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bffa_cmd_t    cmd;
  bffa_status_t status;

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bffa_dp #(.MAP_BYTES(MAP_BYTES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .which_map    (which_map),
    .free_index   (free_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .success      (success),
    .result_value (result_value),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

[src/bffa_checker.sv]
// port-level checks of the bitmap allocator, bound to the top level
// depends on bffa_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bffa_checker import bffa_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic               success,
  input logic [VALUE_W-1:0] result_value
);

  // nothing pending straight out of reset, and the clear pass holds requests
  `AST_NXT_RST(a_rst_rsp_idle, rst, !rsp_valid)
  `AST_NXT_RST(a_rst_clear_stall, rst, req_stall)

  // one word in flight at a time
  `AST_NXT(a_one_at_a_time, req_valid && !req_stall, req_stall)

  // failures carry a zero value
  `AST_IMP(a_fail_zero, rsp_valid && !success, result_value == '0)

  // stalled response holds
  `AST_NXT(a_rsp_hold, rsp_valid && rsp_stall,
           rsp_valid && $stable(success) && $stable(result_value))

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .success      (success),
  .result_value (result_value)
);

[dv/tb_bitmap_first_free_allocator.sv]
// self-checking testbench for the bitmap first-free allocator
// depends on bffa_pkg and bitmap_first_free_allocator; holds its own model of both bitmaps
// a directed opening, then random words under several length and sector settings
`timescale 1ns / 1ps

module tb_bitmap_first_free_allocator import bffa_pkg::*;;

  localparam int MAP_BYTES = 512;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 103;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value;
  } alloc_word_t;

  class alloc_scoreboard;
    logic [7:0]           maps [2][MAP_BYTES];
    logic [CFG_LEN_W-1:0] map_len [2];
    logic [VALUE_W-1:0]   data_start;
    alloc_word_t          expected_q [$];
    int                   errors;
    int                   n_alloc_ok;
    int                   n_alloc_full;
    int                   n_free_ok;
    int                   n_free_out;

    function new();
      for (int m = 0; m < 2; m++) begin
        for (int i = 0; i < MAP_BYTES; i++) maps[m][i] = 8'h00;
      end
      map_len[MAP_NODE] = CFG_LEN_W'(512);
      map_len[MAP_BLOCK] = CFG_LEN_W'(512);
      data_start = '0;
      errors = 0;
      n_alloc_ok = 0;
      n_alloc_full = 0;
      n_free_ok = 0;
      n_free_out = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NODE_LEN: map_len[MAP_NODE] = data[CFG_LEN_W-1:0];
        CFG_BLOCK_LEN: map_len[MAP_BLOCK] = data[CFG_LEN_W-1:0];
        CFG_DATA_START: data_start = data;
        default: ;
      endcase
    endfunction

    function int unsigned effective_len(logic map);
      if (map_len[map] > MAP_BYTES) return MAP_BYTES;
      return map_len[map];
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function void note_request(logic act, logic map, logic [INDEX_W-1:0] idx);
      alloc_word_t word;
      int unsigned len;
      int unsigned byte_at;
      int unsigned pos;
      len = effective_len(map);
      word = '0;
      if (act == ACT_FREE) begin
        byte_at = idx >> 3;
        if (byte_at < len) begin
          maps[map][byte_at][idx[2:0]] = 1'b0;
          word.ok = 1'b1;
          n_free_ok++;
        end else begin
          n_free_out++;
        end
      end else begin
        byte_at = 0;
        while (byte_at < len && maps[map][byte_at] == FULL_BYTE) byte_at++;
        if (byte_at < len) begin
          pos = 0;
          while (pos < 7 && maps[map][byte_at][pos]) pos++;
          maps[map][byte_at][pos] = 1'b1;
          word.value = VALUE_W'(byte_at * 8 + pos);
          if (map == MAP_BLOCK) word.value = word.value + data_start;
          word.ok = 1'b1;
          n_alloc_ok++;
        end else begin
          n_alloc_full++;
        end
      end
      expected_q.push_back(word);
    endfunction

    function void check_result(logic ok, logic [VALUE_W-1:0] value);
      alloc_word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual success %0b value %0h",
                 $time, ok, value);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (ok !== want.ok) begin
        $display("%0t: success mismatch, expected %0b actual %0b", $time, want.ok, ok);
        errors++;
      end
      if (value !== want.value) begin
        $display("%0t: result_value mismatch, expected %0h actual %0h",
                 $time, want.value, value);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic                  action = ACT_ALLOC;
  logic                  which_map = MAP_NODE;
  logic [INDEX_W-1:0]    free_index = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic                  success;
  logic [VALUE_W-1:0]    result_value;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_NODE_LEN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit                    quiet = 1'b0;
  int                    settings_used = 0;

  alloc_scoreboard sb = new();

  bitmap_first_free_allocator #(.MAP_BYTES(MAP_BYTES)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .action(action),
    .which_map(which_map),
    .free_index(free_index),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .success(success),
    .result_value(result_value),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    rsp_stall <= !quiet && ($urandom_range(99) < 19);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_result(success, result_value);
      if (req_valid && !req_stall) sb.note_request(action, which_map, free_index);
    end
  end

  task automatic send_word(input logic act, input logic map, input logic [INDEX_W-1:0] idx);
    while (!quiet && $urandom_range(99) < 19) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    action <= act;
    which_map <= map;
    free_index <= idx;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // waits on the clock first so the last accepted word is already noted
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // upper bits of the length words are junk on purpose
  task automatic write_settings(input logic [CFG_LEN_W-1:0] node_len,
                                input logic [CFG_LEN_W-1:0] blk_len,
                                input logic [VALUE_W-1:0] start);
    logic [CFG_DATA_W-1:0] node_word;
    logic [CFG_DATA_W-1:0] blk_word;
    node_word = {22'($urandom), node_len};
    blk_word = {22'($urandom), blk_len};
    cfg_we <= 1'b1;
    cfg_index <= CFG_NODE_LEN;
    cfg_data <= node_word;
    @(posedge clk);
    cfg_index <= CFG_BLOCK_LEN;
    cfg_data <= blk_word;
    @(posedge clk);
    cfg_index <= CFG_DATA_START;
    cfg_data <= start;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_NODE_LEN, node_word);
    sb.set_reg(CFG_BLOCK_LEN, blk_word);
    sb.set_reg(CFG_DATA_START, start);
    settings_used++;
  endtask

  function automatic logic [CFG_LEN_W-1:0] pick_len();
    case ($urandom_range(9))
      0: return '0;
      1, 2, 3: return CFG_LEN_W'($urandom_range(1, 4));
      4, 5: return CFG_LEN_W'($urandom_range(5, 32));
      6: return CFG_LEN_W'(MAP_BYTES);
      7: return CFG_LEN_W'($urandom_range(MAP_BYTES + 1, 1022));
      8: return '1;
      default: return CFG_LEN_W'($urandom);
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_start();
    case ($urandom_range(3))
      0: return '0;
      1: return VALUE_W'(32'hffff_ffff - $urandom_range(40));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // mostly frees inside the live part of the map, some anywhere
  function automatic logic [INDEX_W-1:0] pick_index(input logic map);
    int unsigned span;
    span = sb.effective_len(map) * 8;
    if (span == 0 || $urandom_range(99) < 20) return INDEX_W'($urandom);
    return INDEX_W'($urandom_range(span - 1));
  endfunction

  initial begin
    logic act;
    logic map;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // one-byte node map to fill it, saturated block map with a wrapping sector base
    write_settings(CFG_LEN_W'(1), '1, 32'hffff_ffff);
    repeat (9) send_word(ACT_ALLOC, MAP_NODE, '0);
    send_word(ACT_FREE, MAP_NODE, INDEX_W'(3));
    send_word(ACT_FREE, MAP_NODE, INDEX_W'(3));
    send_word(ACT_FREE, MAP_NODE, INDEX_W'(8));
    send_word(ACT_FREE, MAP_NODE, '1);
    send_word(ACT_ALLOC, MAP_NODE, '1);
    send_word(ACT_ALLOC, MAP_BLOCK, '0);
    send_word(ACT_ALLOC, MAP_BLOCK, '1);
    send_word(ACT_FREE, MAP_BLOCK, '1);
    send_word(ACT_FREE, MAP_BLOCK, '0);
    drain();

    // zero length on both maps
    write_settings('0, '0, '0);
    send_word(ACT_ALLOC, MAP_NODE, '0);
    send_word(ACT_FREE, MAP_NODE, '0);
    send_word(ACT_ALLOC, MAP_BLOCK, '0);
    send_word(ACT_FREE, MAP_BLOCK, '0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) write_settings(CFG_LEN_W'(MAP_BYTES), CFG_LEN_W'(MAP_BYTES + 1), '0);
      else write_settings(pick_len(), pick_len(), pick_start());
      quiet = (p == 4);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        act = ($urandom_range(99) < 55) ? ACT_ALLOC : ACT_FREE;
        map = $urandom_range(1);
        send_word(act, map, pick_index(map));
      end
      drain();
      quiet = 1'b0;
    end

    repeat (2 * MAP_BYTES + 16) @(posedge clk);
    $display("checked %0d allocations (%0d on a full map) and %0d frees (%0d out of range)",
             sb.n_alloc_ok + sb.n_alloc_full, sb.n_alloc_full,
             sb.n_free_ok + sb.n_free_out, sb.n_free_out);
    $display("over %0d register settings with random idling on both channels", settings_used);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout, %0d words still outstanding", sb.outstanding());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
